FILE: rtl/dfr_pkg.sv
package dfr_pkg;

    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    typedef enum logic [1:0] {
        REG_START_BYTE   = 2'd0,
        REG_END_BYTE     = 2'd1,
        REG_SET_CODE     = 2'd2,
        REG_REQUEST_CODE = 2'd3
    } reg_index_t;

    localparam logic [7:0] START_BYTE_RESET   = 8'd123;
    localparam logic [7:0] END_BYTE_RESET     = 8'd125;
    localparam logic [7:0] SET_CODE_RESET     = 8'd83;
    localparam logic [7:0] REQUEST_CODE_RESET = 8'd82;

    localparam logic [7:0] CHECK_BASE = 8'hFF;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] end_byte;
        logic [7:0] set_code;
        logic [7:0] request_code;
    } cfg_t;

    typedef struct packed {
        logic [15:0] module_id;
        logic [7:0]  kind_code;
        logic [7:0]  function_code;
        logic [31:0] payload_value;
        logic        checksum_ok;
        logic        end_ok;
        logic        is_set;
    } result_t;

endpackage

FILE: rtl/dfr_cfg_regs.sv
module dfr_cfg_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dfr_pkg::ADDR_W-1:0]  paddr,
    input  logic [dfr_pkg::DATA_W-1:0]  pwdata,
    output logic [dfr_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output dfr_pkg::cfg_t               cfg
);

    dfr_pkg::cfg_t      cfg_reg;
    dfr_pkg::cfg_t      cfg_next;
    dfr_pkg::reg_index_t reg_index;
    logic               write_en;

    assign pready    = 1'b1;
    assign reg_index = dfr_pkg::reg_index_t'(paddr[dfr_pkg::ADDR_W-1:2]);
    assign write_en  = psel && penable && pwrite;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (write_en) begin
            case (reg_index)
                dfr_pkg::REG_START_BYTE:   cfg_next.start_byte   = pwdata[7:0];
                dfr_pkg::REG_END_BYTE:     cfg_next.end_byte     = pwdata[7:0];
                dfr_pkg::REG_SET_CODE:     cfg_next.set_code     = pwdata[7:0];
                dfr_pkg::REG_REQUEST_CODE: cfg_next.request_code = pwdata[7:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            dfr_pkg::REG_START_BYTE:   prdata = {24'd0, cfg_reg.start_byte};
            dfr_pkg::REG_END_BYTE:     prdata = {24'd0, cfg_reg.end_byte};
            dfr_pkg::REG_SET_CODE:     prdata = {24'd0, cfg_reg.set_code};
            dfr_pkg::REG_REQUEST_CODE: prdata = {24'd0, cfg_reg.request_code};
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_byte   <= dfr_pkg::START_BYTE_RESET;
            cfg_reg.end_byte     <= dfr_pkg::END_BYTE_RESET;
            cfg_reg.set_code     <= dfr_pkg::SET_CODE_RESET;
            cfg_reg.request_code <= dfr_pkg::REQUEST_CODE_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/dfr_parser.sv
module dfr_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  dfr_pkg::cfg_t     cfg,
    input  logic              byte_valid,
    input  logic [7:0]        rx_byte,
    output logic              res_valid,
    output dfr_pkg::result_t  res
);

    typedef enum logic [3:0] {
        ST_HUNT,
        ST_ID_HI,
        ST_ID_LO,
        ST_KIND,
        ST_FUNC,
        ST_VAL0,
        ST_VAL1,
        ST_VAL2,
        ST_VAL3,
        ST_CHECK,
        ST_CLOSE
    } state_t;

    state_t      state_reg,  state_next;
    logic [15:0] id_reg,     id_next;
    logic [7:0]  kind_reg,   kind_next;
    logic [7:0]  func_reg,   func_next;
    logic [31:0] value_reg,  value_next;
    logic [7:0]  sum_reg,    sum_next;
    logic [7:0]  check_reg,  check_next;
    logic        mode_reg,   mode_next;
    logic        in_payload;

    assign in_payload = (state_reg == ST_ID_HI) || (state_reg == ST_ID_LO) ||
                        (state_reg == ST_KIND)  || (state_reg == ST_FUNC)  ||
                        (state_reg == ST_VAL0)  || (state_reg == ST_VAL1)  ||
                        (state_reg == ST_VAL2)  || (state_reg == ST_VAL3);

    always_comb begin
        state_next = state_reg;
        id_next    = id_reg;
        kind_next  = kind_reg;
        func_next  = func_reg;
        value_next = value_reg;
        sum_next   = sum_reg;
        check_next = check_reg;
        mode_next  = mode_reg;
        if (byte_valid) begin
            if (in_payload) begin
                sum_next = sum_reg + rx_byte;
            end
            case (state_reg)
                ST_ID_HI: begin
                    id_next    = {rx_byte, id_reg[7:0]};
                    state_next = ST_ID_LO;
                end
                ST_ID_LO: begin
                    id_next    = {id_reg[15:8], rx_byte};
                    state_next = ST_KIND;
                end
                ST_KIND: begin
                    kind_next = rx_byte;
                    if (rx_byte == cfg.set_code) begin
                        mode_next = 1'b1;
                    end
                    if (rx_byte == cfg.request_code) begin
                        mode_next = 1'b0;
                    end
                    state_next = ST_FUNC;
                end
                ST_FUNC: begin
                    func_next  = rx_byte;
                    state_next = ST_VAL0;
                end
                ST_VAL0: begin
                    value_next = {value_reg[23:0], rx_byte};
                    state_next = ST_VAL1;
                end
                ST_VAL1: begin
                    value_next = {value_reg[23:0], rx_byte};
                    state_next = ST_VAL2;
                end
                ST_VAL2: begin
                    value_next = {value_reg[23:0], rx_byte};
                    state_next = ST_VAL3;
                end
                ST_VAL3: begin
                    value_next = {value_reg[23:0], rx_byte};
                    state_next = ST_CHECK;
                end
                ST_CHECK: begin
                    check_next = rx_byte;
                    state_next = ST_CLOSE;
                end
                ST_CLOSE: begin
                    state_next = ST_HUNT;
                end
                default: begin
                    if (rx_byte == cfg.start_byte) begin
                        sum_next   = '0;
                        state_next = ST_ID_HI;
                    end else begin
                        state_next = ST_HUNT;
                    end
                end
            endcase
        end
    end

    assign res_valid         = byte_valid && (state_reg == ST_CLOSE);
    assign res.module_id     = id_reg;
    assign res.kind_code     = kind_reg;
    assign res.function_code = func_reg;
    assign res.payload_value = value_reg;
    assign res.checksum_ok   = (check_reg == (dfr_pkg::CHECK_BASE - sum_reg));
    assign res.end_ok        = (rx_byte == cfg.end_byte);
    assign res.is_set        = mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_HUNT;
            mode_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
        end
        id_reg    <= id_next;
        kind_reg  <= kind_next;
        func_reg  <= func_next;
        value_reg <= value_next;
        sum_reg   <= sum_next;
        check_reg <= check_next;
    end

endmodule

FILE: rtl/delimited_frame_receiver_core.sv
// Receives a byte stream, one transfer per cycle while the input is ready, and reassembles
// frames of a start byte, a 16-bit module id, kind and function codes, a 32-bit value, a
// checksum and an end byte, all multi-byte fields high byte first. Bytes outside a frame
// that are not the start byte are dropped, and a start byte inside a frame is ordinary
// data. The frame state advances in a single register stage, and a completed frame appears
// on the result channel in the cycle after its closing byte, so at most one result leaves
// for every eleven input transfers. While a result waits on the result channel, the input
// is held not ready until that result is taken. A result always carries the checksum and
// end-byte checks as flags rather than being discarded. The start byte, end byte, set code
// and request code sit at byte addresses 0, 4, 8 and 12 of the APB port and should only be
// changed while no frame is in progress.
module delimited_frame_receiver_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dfr_pkg::ADDR_W-1:0]  paddr,
    input  logic [dfr_pkg::DATA_W-1:0]  pwdata,
    output logic [dfr_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [7:0]                  s_rx_byte,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [15:0]                 m_module_id,
    output logic [7:0]                  m_kind_code,
    output logic [7:0]                  m_function_code,
    output logic [31:0]                 m_payload_value,
    output logic                        m_checksum_ok,
    output logic                        m_end_ok,
    output logic                        m_is_set
);

    dfr_pkg::cfg_t    cfg;
    dfr_pkg::result_t res;
    dfr_pkg::result_t out_reg,  out_next;
    logic             m_valid_reg, m_valid_next;
    logic             res_valid;
    logic             s_accept;

    dfr_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    dfr_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .byte_valid (s_accept),
        .rx_byte    (s_rx_byte),
        .res_valid  (res_valid),
        .res        (res)
    );

    always_comb begin
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        if (res_valid) begin
            out_next     = res;
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        out_reg <= out_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_module_id     = out_reg.module_id;
    assign m_kind_code     = out_reg.kind_code;
    assign m_function_code = out_reg.function_code;
    assign m_payload_value = out_reg.payload_value;
    assign m_checksum_ok   = out_reg.checksum_ok;
    assign m_end_ok        = out_reg.end_ok;
    assign m_is_set        = out_reg.is_set;

`ifndef SYNTHESIS
    a_res_needs_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> s_accept)
        else $error("Frame completed without an input transfer.");

    a_res_loads_output: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |=> m_valid)
        else $error("Completed frame was not presented on the result channel.");

    a_res_spacing: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |=> !res_valid)
        else $error("Two frames completed in consecutive cycles.");
`endif

endmodule

FILE: dv/testbench.sv
module testbench;

    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int FRAMES_PER_PHASE = 14;

    typedef enum {SINK_OPEN, SINK_RANDOM, SINK_STALLS} sink_mode_t;

    class frame_scoreboard;
        dfr_pkg::cfg_t    cfg;
        logic [3:0]       position;
        logic [15:0]      id_acc;
        logic [7:0]       kind_acc;
        logic [7:0]       func_acc;
        logic [31:0]      value_acc;
        logic [7:0]       sum_acc;
        logic [7:0]       check_acc;
        logic             set_flag;
        dfr_pkg::result_t frames_due[$];
        int               errors;
        int               frames_checked;

        function new();
            cfg.start_byte   = dfr_pkg::START_BYTE_RESET;
            cfg.end_byte     = dfr_pkg::END_BYTE_RESET;
            cfg.set_code     = dfr_pkg::SET_CODE_RESET;
            cfg.request_code = dfr_pkg::REQUEST_CODE_RESET;
            position  = '0;
            id_acc    = '0;
            kind_acc  = '0;
            func_acc  = '0;
            value_acc = '0;
            sum_acc   = '0;
            check_acc = '0;
            set_flag  = 1'b0;
            errors    = 0;
            frames_checked = 0;
        endfunction

        function void write_reg(dfr_pkg::reg_index_t idx, logic [7:0] v);
            case (idx)
                dfr_pkg::REG_START_BYTE:   cfg.start_byte   = v;
                dfr_pkg::REG_END_BYTE:     cfg.end_byte     = v;
                dfr_pkg::REG_SET_CODE:     cfg.set_code     = v;
                dfr_pkg::REG_REQUEST_CODE: cfg.request_code = v;
                default: ;
            endcase
        endfunction

        // Called for every accepted input transfer; queues a frame result on the closing byte.
        function void note_byte(logic [7:0] b);
            dfr_pkg::result_t r;
            if (position >= 4'd1 && position <= 4'd8)
                sum_acc = sum_acc + b;
            case (position)
                4'd1: begin
                    id_acc[15:8] = b;
                    position = 4'd2;
                end
                4'd2: begin
                    id_acc[7:0] = b;
                    position = 4'd3;
                end
                4'd3: begin
                    kind_acc = b;
                    if (b == cfg.set_code)
                        set_flag = 1'b1;
                    if (b == cfg.request_code)
                        set_flag = 1'b0;
                    position = 4'd4;
                end
                4'd4: begin
                    func_acc = b;
                    position = 4'd5;
                end
                4'd5, 4'd6, 4'd7, 4'd8: begin
                    value_acc = {value_acc[23:0], b};
                    position = position + 4'd1;
                end
                4'd9: begin
                    check_acc = b;
                    position = 4'd10;
                end
                4'd10: begin
                    r.module_id     = id_acc;
                    r.kind_code     = kind_acc;
                    r.function_code = func_acc;
                    r.payload_value = value_acc;
                    r.checksum_ok   = (check_acc == 8'(dfr_pkg::CHECK_BASE - sum_acc));
                    r.end_ok        = (b == cfg.end_byte);
                    r.is_set        = set_flag;
                    frames_due.push_back(r);
                    position = 4'd0;
                end
                default: begin
                    if (b == cfg.start_byte) begin
                        sum_acc = '0;
                        position = 4'd1;
                    end else begin
                        position = 4'd0;
                    end
                end
            endcase
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s expected %h, got %h", $time, field, want, got);
            end
        endfunction

        function void check_frame(dfr_pkg::result_t got);
            dfr_pkg::result_t want;
            if (frames_due.size() == 0) begin
                errors++;
                $display("%0t: frame result expected none, got module_id %h", $time,
                         got.module_id);
                return;
            end
            want = frames_due.pop_front();
            frames_checked++;
            compare("module_id", 32'(want.module_id), 32'(got.module_id));
            compare("kind_code", 32'(want.kind_code), 32'(got.kind_code));
            compare("function_code", 32'(want.function_code), 32'(got.function_code));
            compare("payload_value", want.payload_value, got.payload_value);
            compare("checksum_ok", 32'(want.checksum_ok), 32'(got.checksum_ok));
            compare("end_ok", 32'(want.end_ok), 32'(got.end_ok));
            compare("is_set", 32'(want.is_set), 32'(got.is_set));
        endfunction
    endclass

    logic                        aclk;
    logic                        aresetn   = 1'b0;
    logic                        psel      = 1'b0;
    logic                        penable   = 1'b0;
    logic                        pwrite    = 1'b0;
    logic [dfr_pkg::ADDR_W-1:0]  paddr     = '0;
    logic [dfr_pkg::DATA_W-1:0]  pwdata    = '0;
    logic [dfr_pkg::DATA_W-1:0]  prdata;
    logic                        pready;
    logic                        s_valid   = 1'b0;
    logic                        s_ready;
    logic [7:0]                  s_rx_byte = '0;
    logic                        m_valid;
    logic                        m_ready   = 1'b0;
    logic [15:0]                 m_module_id;
    logic [7:0]                  m_kind_code;
    logic [7:0]                  m_function_code;
    logic [31:0]                 m_payload_value;
    logic                        m_checksum_ok;
    logic                        m_end_ok;
    logic                        m_is_set;

    frame_scoreboard  sb;
    dfr_pkg::result_t seen;
    sink_mode_t       sink_mode = SINK_OPEN;
    int               stall_left = 0;
    int               quiet_cycles = 0;
    int               burst_left = 0;
    bit               gaps_on = 1'b1;
    int               bytes_sent = 0;
    int               frames_sent = 0;
    int               settings_done = 1;

    delimited_frame_receiver_core uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_module_id     (m_module_id),
        .m_kind_code     (m_kind_code),
        .m_function_code (m_function_code),
        .m_payload_value (m_payload_value),
        .m_checksum_ok   (m_checksum_ok),
        .m_end_ok        (m_end_ok),
        .m_is_set        (m_is_set)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        case (sink_mode)
            SINK_OPEN: m_ready <= 1'b1;
            SINK_RANDOM: m_ready <= 1'($urandom_range(0, 1));
            default: begin
                if (stall_left != 0) begin
                    stall_left <= stall_left - 1;
                    m_ready <= 1'b0;
                end else if ($urandom_range(0, 11) == 0) begin
                    stall_left <= $urandom_range(1, 40);
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                end
            end
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                seen.module_id     = m_module_id;
                seen.kind_code     = m_kind_code;
                seen.function_code = m_function_code;
                seen.payload_value = m_payload_value;
                seen.checksum_ok   = m_checksum_ok;
                seen.end_ok        = m_end_ok;
                seen.is_set        = m_is_set;
                sb.check_frame(seen);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d frame results outstanding.",
                         $time, WATCHDOG_LIMIT, sb.frames_due.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            2: return sb.cfg.start_byte;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (gaps_on && burst_left == 0) begin
            gap = $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        sb.note_byte(b);
        bytes_sent++;
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic send_frame(input logic [15:0] id, input logic [7:0] kind,
                              input logic [7:0] func, input logic [31:0] value,
                              input bit sum_good, input bit end_good);
        logic [7:0] body [8];
        logic [7:0] total;
        total = '0;
        body = '{id[15:8], id[7:0], kind, func,
                 value[31:24], value[23:16], value[15:8], value[7:0]};
        send_byte(sb.cfg.start_byte);
        foreach (body[i]) begin
            send_byte(body[i]);
            total = total + body[i];
        end
        if (sum_good)
            send_byte(8'(dfr_pkg::CHECK_BASE - total));
        else
            send_byte(8'(dfr_pkg::CHECK_BASE - total) ^ 8'($urandom_range(1, 255)));
        if (end_good)
            send_byte(sb.cfg.end_byte);
        else
            send_byte(sb.cfg.end_byte ^ 8'($urandom_range(1, 255)));
        frames_sent++;
    endtask

    task automatic random_frame();
        logic [7:0] kind;
        int noise;
        int partial;
        case ($urandom_range(0, 2))
            0: kind = sb.cfg.set_code;
            1: kind = sb.cfg.request_code;
            default: kind = pick_byte();
        endcase
        noise = $urandom_range(0, 2);
        repeat (noise) send_byte(pick_byte());
        // A truncated frame swallows the start of the next one as ordinary data.
        if ($urandom_range(0, 9) == 0) begin
            partial = $urandom_range(0, 9);
            send_byte(sb.cfg.start_byte);
            repeat (partial) send_byte(pick_byte());
        end
        send_frame({pick_byte(), pick_byte()}, kind, pick_byte(),
                   {pick_byte(), pick_byte(), pick_byte(), pick_byte()},
                   $urandom_range(0, 4) != 0, $urandom_range(0, 5) != 0);
    endtask

    task automatic apb_write(input dfr_pkg::reg_index_t idx, input logic [7:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= dfr_pkg::ADDR_W'(4 * int'(idx));
        pwdata <= {24'($urandom), v};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.write_reg(idx, v);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Completes any open frame and waits for every frame result to be taken.
    task automatic settle();
        while (sb.position != 4'd0)
            send_byte(pick_byte());
        s_valid <= 1'b0;
        while (sb.frames_due.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic run_phase(input logic [7:0] start_v, end_v, set_v, request_v,
                             input sink_mode_t mode, input bit gaps);
        apb_write(dfr_pkg::REG_START_BYTE, start_v);
        apb_write(dfr_pkg::REG_END_BYTE, end_v);
        apb_write(dfr_pkg::REG_SET_CODE, set_v);
        apb_write(dfr_pkg::REG_REQUEST_CODE, request_v);
        sink_mode <= mode;
        gaps_on = gaps;
        burst_left = 0;
        repeat (FRAMES_PER_PHASE) random_frame();
        settle();
        settings_done++;
    endtask

    initial begin
        logic [7:0] shared_code;
        sb = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        sink_mode <= SINK_OPEN;
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(16'hFFFF, sb.cfg.set_code, 8'h00,
                   {8'hFF, sb.cfg.start_byte, 16'hFFFF}, 1'b1, 1'b1);
        send_frame(16'h0000, sb.cfg.request_code, 8'hFF, 32'h0000_0000, 1'b0, 1'b0);
        settle();

        run_phase(8'h00, 8'hFF, 8'hFF, 8'h00, SINK_RANDOM, 1'b1);
        run_phase(8'hFF, 8'h00, 8'h00, 8'hFF, SINK_STALLS, 1'b0);
        shared_code = 8'($urandom);
        run_phase(8'($urandom), 8'($urandom), shared_code, shared_code, SINK_OPEN, 1'b1);
        run_phase(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  SINK_STALLS, 1'b1);
        repeat (16) @(posedge aclk);

        $display("Sent %0d byte transfers holding %0d frames under %0d register settings;",
                 bytes_sent, frames_sent, settings_done);
        $display("checked %0d frame results, %0d errors.", sb.frames_checked, sb.errors);
        if (sb.errors == 0 && sb.frames_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: sim.f
rtl/dfr_pkg.sv
rtl/dfr_cfg_regs.sv
rtl/dfr_parser.sv
rtl/delimited_frame_receiver_core.sv
dv/testbench.sv
